// ===== src/gvfm_pkg.sv =====
// Shared constants, types and address helper for the greedy voxel face mesher.
package gvfm_pkg;

    localparam int BS    = 16;
    localparam int SIDE  = BS + 2;
    localparam int VOX   = SIDE * SIDE * SIDE;
    localparam int AW    = $clog2(VOX);
    localparam int CW    = $clog2(BS);
    localparam int PW    = $clog2(BS + 1);
    localparam int BCW   = $clog2(BS * BS + 1);
    localparam int XW    = $clog2(SIDE);

    localparam logic        OPC_WRITE  = 1'b0;
    localparam logic        OPC_PULL   = 1'b1;
    localparam logic [15:0] MASS_RESET = 16'd205;

    localparam logic [1:0] AXIS_X = 2'd0;
    localparam logic [1:0] AXIS_Y = 2'd1;
    localparam logic [1:0] AXIS_Z = 2'd2;

    typedef enum logic [3:0] {
        S_IDLE,
        S_PULL,
        S_BUILD,
        S_FIND,
        S_HEIGHT,
        S_CLEAR,
        S_NEXT,
        S_EMIT
    } t_state;

    typedef struct packed {
        logic write;
        logic build;
        logic set_loaded;
        logic find;
        logic height;
        logic clear;
        logic next_slice;
        logic emit;
    } t_cmd;

    typedef struct packed {
        logic build_done;
        logic found;
        logic row_last;
        logic height_ok;
        logic clear_last;
        logic loaded;
        logic all_done;
        logic out_free;
    } t_stat;

    function automatic logic [AW-1:0] vaddr(input logic [XW-1:0] x,
                                            input logic [XW-1:0] y,
                                            input logic [XW-1:0] z);
        logic [AW-1:0] yz;
        yz = AW'(y) + AW'(SIDE) * AW'(z);
        return AW'(x) + AW'(SIDE) * yz;
    endfunction

endpackage

// ===== src/greedy_voxel_face_mesher.sv =====
// Top level of the greedy voxel face mesher.
//
// Input channel (i_in_valid / o_in_ready): an item with opcode 0 writes one
// voxel of the bordered block and restarts the sweep; it returns nothing.
// An item with opcode 1 pulls the next merged rectangle.
// Output channel (o_out_valid / i_out_ready): one item per pull; sweep_done
// set means no rectangle is left and all other fields are zero.
// i_cfg_we / i_cfg_data load the wet mass threshold (reset 205); write it
// only while the block is idle.
// A pull is dispatched, scans the mask row by row, grows the height of the
// found rectangle, clears it from the mask and registers the result. Each
// new slice first builds its mask, one cell per cycle from two copies of
// the voxel store read in parallel. A full empty sweep spans 102 slices.
// Reset clears the cursor and the output valid flag; the voxel store is not
// cleared and holds garbage until written. A stalled receiver holds the
// result in the output register; the next item is still accepted, and a
// pull waits only for the register to free before loading its result.
module greedy_voxel_face_mesher import gvfm_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [15:0] i_cfg_data,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic        i_opcode,
    input  logic [5:0]  i_voxel_x,
    input  logic [5:0]  i_voxel_y,
    input  logic [5:0]  i_voxel_z,
    input  logic [15:0] i_water_mass,
    input  logic        i_is_solid,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [1:0]  o_face_axis,
    output logic        o_face_negative,
    output logic [4:0]  o_face_plane,
    output logic [3:0]  o_start_u,
    output logic [3:0]  o_start_v,
    output logic [4:0]  o_span_u,
    output logic [4:0]  o_span_v,
    output logic        o_sweep_done
);

    t_cmd  cmd;
    t_stat stat;

    gvfm_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_opcode   (i_opcode),
        .o_in_ready (o_in_ready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    gvfm_dp u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_data      (i_cfg_data),
        .i_voxel_x       (i_voxel_x),
        .i_voxel_y       (i_voxel_y),
        .i_voxel_z       (i_voxel_z),
        .i_water_mass    (i_water_mass),
        .i_is_solid      (i_is_solid),
        .i_out_ready     (i_out_ready),
        .i_cmd           (cmd),
        .o_stat          (stat),
        .o_out_valid     (o_out_valid),
        .o_face_axis     (o_face_axis),
        .o_face_negative (o_face_negative),
        .o_face_plane    (o_face_plane),
        .o_start_u       (o_start_u),
        .o_start_v       (o_start_v),
        .o_span_u        (o_span_u),
        .o_span_v        (o_span_v),
        .o_sweep_done    (o_sweep_done)
    );

endmodule

// ===== src/gvfm_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module gvfm_ram #(
    parameter int WIDTH = 2,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== src/gvfm_ctrl.sv =====
// Sequencing state machine for voxel writes and rectangle pulls.
module gvfm_ctrl import gvfm_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_in_valid,
    input  logic  i_opcode,
    output logic  o_in_ready,
    input  t_stat i_stat,
    output t_cmd  o_cmd
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid && i_opcode == OPC_PULL) n_state = S_PULL;
            end
            S_PULL: begin
                if (i_stat.all_done)     n_state = S_EMIT;
                else if (!i_stat.loaded) n_state = S_BUILD;
                else                     n_state = S_FIND;
            end
            S_BUILD: begin
                if (i_stat.build_done) n_state = S_FIND;
            end
            S_FIND: begin
                if (i_stat.found)         n_state = S_HEIGHT;
                else if (i_stat.row_last) n_state = S_NEXT;
            end
            S_HEIGHT: begin
                if (!i_stat.height_ok) n_state = S_CLEAR;
            end
            S_CLEAR: begin
                if (i_stat.clear_last) n_state = S_EMIT;
            end
            S_NEXT: begin
                n_state = S_PULL;
            end
            S_EMIT: begin
                if (i_stat.out_free) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready  = 1'b1;
                o_cmd.write = i_in_valid && i_opcode == OPC_WRITE;
            end
            S_BUILD: begin
                o_cmd.build      = 1'b1;
                o_cmd.set_loaded = i_stat.build_done;
            end
            S_FIND:   o_cmd.find       = 1'b1;
            S_HEIGHT: o_cmd.height     = 1'b1;
            S_CLEAR:  o_cmd.clear      = 1'b1;
            S_NEXT:   o_cmd.next_slice = 1'b1;
            S_EMIT:   o_cmd.emit       = i_stat.out_free;
            default: begin
                o_cmd      = '0;
                o_in_ready = 1'b0;
            end
        endcase
    end

endmodule

// ===== src/gvfm_dp.sv =====
// Datapath: voxel store, slice mask, sweep cursor, rectangle growth and result register.
module gvfm_dp import gvfm_pkg::*; (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_cfg_we,
    input  logic [15:0]   i_cfg_data,
    input  logic [5:0]    i_voxel_x,
    input  logic [5:0]    i_voxel_y,
    input  logic [5:0]    i_voxel_z,
    input  logic [15:0]   i_water_mass,
    input  logic          i_is_solid,
    input  logic          i_out_ready,
    input  t_cmd          i_cmd,
    output t_stat         o_stat,
    output logic          o_out_valid,
    output logic [1:0]    o_face_axis,
    output logic          o_face_negative,
    output logic [4:0]    o_face_plane,
    output logic [3:0]    o_start_u,
    output logic [3:0]    o_start_v,
    output logic [4:0]    o_span_u,
    output logic [4:0]    o_span_v,
    output logic          o_sweep_done
);

    logic [15:0]    r_min_mass;
    logic [1:0]     r_axis;
    logic           r_neg;
    logic [PW-1:0]  r_pl1;
    logic [CW-1:0]  r_row;
    logic [PW-1:0]  r_col;
    logic           r_loaded;
    logic           r_done;
    logic [BCW-1:0] r_bcnt;
    logic           r_bvalid;
    logic [BCW-2:0] r_bidx;
    logic [BS-1:0]  r_mask [BS];
    logic [CW-1:0]  r_u;
    logic [PW-1:0]  r_w;
    logic [PW-1:0]  r_h;
    logic [PW-1:0]  r_k;
    logic [BS-1:0]  r_wmask;

    logic           r_ov;
    logic [1:0]     r_o_axis;
    logic           r_o_neg;
    logic [4:0]     r_o_plane;
    logic [3:0]     r_o_u;
    logic [3:0]     r_o_v;
    logic [4:0]     r_o_w;
    logic [4:0]     r_o_h;
    logic           r_o_done;

    // voxel write
    logic [6:0]    xb, yb, zb;
    logic          in_box;
    logic [AW-1:0] waddr;
    logic [1:0]    wdata;
    logic          we;

    assign xb     = {i_voxel_x[5], i_voxel_x} + 7'sd1;
    assign yb     = {i_voxel_y[5], i_voxel_y} + 7'sd1;
    assign zb     = {i_voxel_z[5], i_voxel_z} + 7'sd1;
    assign in_box = !xb[6] && xb < 7'(SIDE) && !yb[6] && yb < 7'(SIDE)
                    && !zb[6] && zb < 7'(SIDE);
    assign waddr  = vaddr(xb[XW-1:0], yb[XW-1:0], zb[XW-1:0]);
    assign wdata  = {(i_water_mass > r_min_mass) && !i_is_solid, i_is_solid};
    assign we     = i_cmd.write && in_box;

    // build read addresses
    logic [XW-1:0] ca, cb, ub, vb;
    logic [AW-1:0] addr_a, addr_b;
    logic [1:0]    rd_a, rd_b;
    logic          face;

    assign ca = XW'(r_pl1);
    assign cb = XW'(r_pl1) + XW'(1);
    assign ub = XW'(r_bcnt[CW-1:0]) + XW'(1);
    assign vb = XW'(r_bcnt[2*CW-1:CW]) + XW'(1);

    always_comb begin
        case (r_axis)
            AXIS_X: begin
                addr_a = vaddr(ca, ub, vb);
                addr_b = vaddr(cb, ub, vb);
            end
            AXIS_Y: begin
                addr_a = vaddr(vb, ca, ub);
                addr_b = vaddr(vb, cb, ub);
            end
            default: begin
                addr_a = vaddr(ub, vb, ca);
                addr_b = vaddr(ub, vb, cb);
            end
        endcase
    end

    gvfm_ram #(.WIDTH(2), .DEPTH(VOX)) u_ram_a (
        .i_clk(i_clk), .i_we(we), .i_waddr(waddr), .i_wdata(wdata),
        .i_raddr(addr_a), .o_rdata(rd_a)
    );

    gvfm_ram #(.WIDTH(2), .DEPTH(VOX)) u_ram_b (
        .i_clk(i_clk), .i_we(we), .i_waddr(waddr), .i_wdata(wdata),
        .i_raddr(addr_b), .o_rdata(rd_b)
    );

    assign face = r_neg ? (rd_b[1] && !rd_a[1] && !rd_a[0])
                        : (rd_a[1] && !rd_b[1] && !rd_b[0]);

    // one mask row read per cycle
    logic [PW:0]   ptr;
    logic [CW-1:0] sel;
    logic [BS-1:0] row;
    logic [BS-1:0] cand;
    logic [BS-1:0] ones;
    logic [BS-1:0] run;
    logic [CW-1:0] fu;
    logic [PW-1:0] fw;
    logic [BS-1:0] fmask;

    assign ptr  = {1'b0, PW'(r_row)} + {1'b0, (i_cmd.clear ? r_k : r_h)};
    assign sel  = i_cmd.find ? r_row : ptr[CW-1:0];
    assign row  = r_mask[sel];
    assign ones = '1;
    assign cand = row & (r_col >= PW'(BS) ? '0 : (ones << r_col));

    always_comb begin
        fu = '0;
        for (int i = BS - 1; i >= 0; i--) begin
            if (cand[i]) fu = CW'(i);
        end
    end

    assign run = row >> fu;

    always_comb begin
        fw = PW'(BS);
        for (int i = BS - 1; i >= 0; i--) begin
            if (!run[i]) fw = PW'(i);
        end
    end

    assign fmask = (ones >> (PW'(BS) - fw)) << fu;

    assign o_stat.build_done = r_bcnt[BCW-1] && !r_bvalid;
    assign o_stat.found      = |cand;
    assign o_stat.row_last   = r_row == CW'(BS - 1);
    assign o_stat.height_ok  = ptr < (PW+1)'(BS) && (row & r_wmask) == r_wmask;
    assign o_stat.clear_last = r_k + PW'(1) == r_h;
    assign o_stat.loaded     = r_loaded;
    assign o_stat.all_done   = r_done;
    assign o_stat.out_free   = !r_ov || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_mass <= MASS_RESET;
            r_axis     <= AXIS_X;
            r_neg      <= 1'b1;
            r_pl1      <= '0;
            r_row      <= '0;
            r_col      <= '0;
            r_loaded   <= 1'b0;
            r_done     <= 1'b0;
            r_bcnt     <= '0;
            r_bvalid   <= 1'b0;
            r_ov       <= 1'b0;
        end else begin
            if (i_cfg_we) r_min_mass <= i_cfg_data;
            if (i_cmd.write) begin
                r_axis   <= AXIS_X;
                r_neg    <= 1'b1;
                r_pl1    <= '0;
                r_row    <= '0;
                r_col    <= '0;
                r_loaded <= 1'b0;
                r_done   <= 1'b0;
                r_bcnt   <= '0;
            end
            if (i_cmd.build) begin
                r_bvalid <= !r_bcnt[BCW-1];
                if (!r_bcnt[BCW-1]) r_bcnt <= r_bcnt + BCW'(1);
            end
            if (i_cmd.set_loaded) begin
                r_loaded <= 1'b1;
                r_row    <= '0;
                r_col    <= '0;
            end
            if (i_cmd.find && !(|cand) && r_row != CW'(BS - 1)) begin
                r_row <= r_row + CW'(1);
                r_col <= '0;
            end
            if (i_cmd.next_slice) begin
                r_loaded <= 1'b0;
                r_row    <= '0;
                r_col    <= '0;
                r_bcnt   <= '0;
                if (r_pl1 == PW'(BS)) begin
                    r_pl1 <= '0;
                    if (r_neg) begin
                        r_neg <= 1'b0;
                    end else begin
                        r_neg <= 1'b1;
                        if (r_axis == AXIS_Z) begin
                            r_axis <= AXIS_X;
                            r_done <= 1'b1;
                        end else begin
                            r_axis <= r_axis + 2'd1;
                        end
                    end
                end else begin
                    r_pl1 <= r_pl1 + PW'(1);
                end
            end
            if (i_cmd.emit) begin
                r_ov <= 1'b1;
                if (!r_done) r_col <= PW'(r_u) + r_w;
            end else if (i_out_ready) begin
                r_ov <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_bvalid) r_mask[r_bidx[2*CW-1:CW]][r_bidx[CW-1:0]] <= face;
        r_bidx <= r_bcnt[BCW-2:0];
        if (i_cmd.find && |cand) begin
            r_u     <= fu;
            r_w     <= fw;
            r_h     <= PW'(1);
            r_k     <= '0;
            r_wmask <= fmask;
        end
        if (i_cmd.height && o_stat.height_ok) r_h <= r_h + PW'(1);
        if (i_cmd.clear) begin
            r_mask[sel] <= row & ~r_wmask;
            r_k         <= r_k + PW'(1);
        end
        if (i_cmd.emit) begin
            r_o_done  <= r_done;
            r_o_axis  <= r_done ? 2'd0 : r_axis;
            r_o_neg   <= r_done ? 1'b0 : r_neg;
            r_o_plane <= r_done ? 5'd0 : 5'(r_pl1);
            r_o_u     <= r_done ? 4'd0 : 4'(r_u);
            r_o_v     <= r_done ? 4'd0 : 4'(r_row);
            r_o_w     <= r_done ? 5'd0 : 5'(r_w);
            r_o_h     <= r_done ? 5'd0 : 5'(r_h);
        end
    end

    assign o_out_valid     = r_ov;
    assign o_face_axis     = r_o_axis;
    assign o_face_negative = r_o_neg;
    assign o_face_plane    = r_o_plane;
    assign o_start_u       = r_o_u;
    assign o_start_v       = r_o_v;
    assign o_span_u        = r_o_w;
    assign o_span_v        = r_o_h;
    assign o_sweep_done    = r_o_done;

endmodule

// ===== src/gvfm_checker.sv =====
// Port-level assertions for the greedy voxel face mesher, bound to the top level.
module gvfm_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_in_valid,
    input logic       o_in_ready,
    input logic       i_opcode,
    input logic       o_out_valid,
    input logic       i_out_ready,
    input logic [1:0] o_face_axis,
    input logic       o_face_negative,
    input logic [4:0] o_face_plane,
    input logic [3:0] o_start_u,
    input logic [3:0] o_start_v,
    input logic [4:0] o_span_u,
    input logic [4:0] o_span_v,
    input logic       o_sweep_done
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid)
        else $error("result item dropped while stalled");

    a_done_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_sweep_done |-> o_face_axis == 2'd0 && !o_face_negative
        && o_face_plane == 5'd0 && o_span_u == 5'd0 && o_span_v == 5'd0)
        else $error("done item carries nonzero fields");

    a_rect_shape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_sweep_done |-> o_span_u != 5'd0 && o_span_v != 5'd0
        && o_face_axis != 2'd3 && ({1'b0, o_start_u} + o_span_u) <= 5'd16
        && ({1'b0, o_start_v} + o_span_v) <= 5'd16)
        else $error("rectangle out of slice bounds");

    a_pull_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready && i_opcode |=> !o_in_ready)
        else $error("pull did not occupy the block");

    a_reset_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

endmodule

bind greedy_voxel_face_mesher gvfm_checker u_gvfm_checker (.*);
